[hdl/wsd_pkg.sv]
// Package for the waveshaper distortion core: configuration register indexes,
// fixed-point constants and the elaboration-time builders of the sine and arctangent tables.
// Used by the core and the table ROM; depends on nothing.
package wsd_pkg;

  localparam int TABLE_BITS_DEF = 10;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRIVE = 3'd0,
    CFG_WET   = 3'd1,
    CFG_GAIN  = 3'd2,
    CFG_CURVE = 3'd3,
    CFG_BIAS  = 3'd4
  } cfg_index_t;

  typedef enum logic {
    TAB_SINE = 1'b0,
    TAB_ATAN = 1'b1
  } table_kind_t;

  typedef enum logic [1:0] {
    REGION_SINE_CUBIC = 2'd0,
    REGION_CUBIC_ATAN = 2'd1,
    REGION_ATAN_HARD  = 2'd2
  } region_t;

  localparam logic [15:0] DRIVE_RST = 16'd16384;
  localparam logic [15:0] WET_RST   = 16'd32768;
  localparam logic [15:0] GAIN_RST  = 16'd22938;
  localparam logic [15:0] CURVE_RST = 16'd16384;
  localparam logic [15:0] BIAS_RST  = 16'd16384;

  localparam logic [15:0] SHAPE_B1  = 16'd10813;
  localparam logic [15:0] SHAPE_B2  = 16'd21627;
  localparam logic [15:0] HARD_KNEE = 16'd6554;

  localparam longint Q28_ONE     = 64'sd1 <<< 28;
  localparam longint PI_Q28      = 64'sd843314857;
  localparam longint HALF_PI_Q28 = 64'sd421657428;

  // Long division with the quotient truncated toward zero. Only the table
  // builders call it, so it runs at elaboration and never becomes logic.
  function automatic longint div_trunc(input longint n, input longint d);
    logic [63:0] un;
    logic [63:0] ud;
    logic [63:0] q;
    logic [64:0] rem;
    un = (n < 0) ? 64'(-n) : 64'(n);
    ud = (d < 0) ? 64'(-d) : 64'(d);
    q = '0;
    rem = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[63:0], un[k]};
      if (rem >= {1'b0, ud}) begin
        rem = rem - {1'b0, ud};
        q[k] = 1'b1;
      end
    end
    return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint isqrt64(input longint v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] bitv;
    v = v_in;
    r = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(r);
  endfunction

  // Taylor series of sin on 0..pi/2, Q28 in and out.
  function automatic longint sin_q28(input longint th);
    longint t2;
    longint term;
    longint sum;
    t2 = (th * th) >>> 28;
    term = th;
    sum = 0;
    for (int k = 0; k < 10; k++) begin
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
      term = div_trunc((term * t2) >>> 28, longint'((2 * k + 2) * (2 * k + 3)));
    end
    return (sum < 0) ? 64'sd0 : sum;
  endfunction

  // Arctangent by reflection, two half-angle reductions and a short series.
  function automatic longint atan_q28(input longint z);
    logic inv;
    longint w;
    longint w2;
    longint term;
    longint sum;
    inv = z > Q28_ONE;
    w = inv ? div_trunc(Q28_ONE * Q28_ONE, z) : z;
    for (int k = 0; k < 2; k++) begin
      w = div_trunc(w * Q28_ONE, Q28_ONE + isqrt64(Q28_ONE * Q28_ONE + w * w));
    end
    w2 = (w * w) >>> 28;
    term = w;
    sum = 0;
    for (int k = 0; k < 12; k++) begin
      if (k % 2 == 1) sum = sum - div_trunc(term, longint'(2 * k + 1));
      else sum = sum + div_trunc(term, longint'(2 * k + 1));
      term = (term * w2) >>> 28;
    end
    sum = sum * 4;
    return inv ? HALF_PI_Q28 - sum : sum;
  endfunction

  function automatic logic [15:0] sin_entry(input longint i, input int tb);
    longint th;
    longint ts;
    th = (i * PI_Q28) >>> tb;
    ts = (th > HALF_PI_Q28) ? PI_Q28 - th : th;
    if (ts < 0) ts = 0;
    return 16'((sin_q28(ts) + 64'sd4096) >>> 13);
  endfunction

  function automatic logic [15:0] atan_entry(input longint i, input int tb);
    longint th;
    longint a;
    th = (i * PI_Q28) >>> tb;
    a = atan_q28(th);
    return 16'(div_trunc(a * 64'sd65536 + PI_Q28 / 2, PI_Q28));
  endfunction

endpackage

[hdl/wsd_if.sv]
// Valid/ready channel interfaces for the waveshaper distortion core.
// Payload widths are the fixed Q1.15 sample formats; no dependencies.
interface wsd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               pass_through;

  modport source(output valid, output sample, output pass_through, input ready);
  modport sink(input valid, input sample, input pass_through, output ready);
endinterface

interface wsd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_sample;
  logic               clipped;

  modport source(output valid, output out_sample, output clipped, input ready);
  modport sink(input valid, input out_sample, input clipped, output ready);
endinterface

[hdl/waveshaper_distortion_core.sv]
// Top level of the waveshaper distortion core: configuration registers and the
// fifteen-stage sample pipeline. Depends on wsd_pkg, wsd_if and wsd_table_rom.
//
// One signed Q1.15 sample enters per beat and one shaped sample leaves per beat.
// The pipeline is fifteen register stages deep, and when the output side never
// stalls the block sustains one sample per clock. The depth is set mostly by
// the hard-knee curve, whose division runs through a five-stage radix-2 divider
// at three quotient bits per stage, and by the final gain multiply, which is split
// into two partial products. Each stage holds its beat only while the stage after
// it is full and stalled, so bubbles collapse and input beats are still taken
// while a finished result waits on the output. Configuration is a plain write
// port; registers should be written only while no samples are in flight.
module waveshaper_distortion_core #(
  parameter int TABLE_BITS = wsd_pkg::TABLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  wsd_in_if.sink                            in_ch,
  wsd_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [wsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wsd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int NS = 15;

  // Everything a sample carries through the pipeline. Each stage fills the
  // fields it produces; unused fields are trimmed by synthesis.
  typedef struct packed {
    logic signed [15:0]     s;
    logic                   pt;
    logic signed [17:0]     t;
    logic signed [37:0]     x31;
    logic signed [16:0]     x;
    logic                   neg;
    logic [TABLE_BITS-1:0]  idx;
    logic [15:0]            frac;
    logic [15:0]            dv;
    logic [15:0]            rem;
    logic [14:0]            nb;
    logic [14:0]            q;
    logic [31:0]            xsq;
    logic signed [49:0]     x3;
    logic signed [17:0]     sy;
    logic signed [17:0]     ay;
    logic signed [17:0]     cub;
    logic signed [17:0]     hy;
    logic signed [36:0]     pa;
    logic signed [36:0]     pb;
    logic signed [23:0]     curve_y;
    logic signed [32:0]     ps;
    logic signed [40:0]     pd;
    logic signed [22:0]     oh;
    logic [18:0]            ol;
    logic signed [39:0]     ph;
    logic [34:0]            pl;
    logic signed [30:0]     r;
    logic signed [15:0]     out_sample;
    logic                   clipped;
  } pipe_t;

  typedef struct packed {
    logic [15:0] rem;
    logic [14:0] nb;
    logic [14:0] q;
  } div_t;

  // Configuration registers.
  logic [15:0] drive_r, wet_r, gain_r, curve_r, bias_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r <= wsd_pkg::DRIVE_RST;
      wet_r   <= wsd_pkg::WET_RST;
      gain_r  <= wsd_pkg::GAIN_RST;
      curve_r <= wsd_pkg::CURVE_RST;
      bias_r  <= wsd_pkg::BIAS_RST;
    end else if (cfg_we) begin
      unique case (wsd_pkg::cfg_index_t'(cfg_index))
        wsd_pkg::CFG_DRIVE: drive_r <= cfg_data;
        wsd_pkg::CFG_WET:   wet_r   <= cfg_data;
        wsd_pkg::CFG_GAIN:  gain_r  <= cfg_data;
        wsd_pkg::CFG_CURVE: curve_r <= cfg_data;
        wsd_pkg::CFG_BIAS:  bias_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Values derived from configuration. They are static while samples flow.
  logic [19:0]      drive_gain;
  wsd_pkg::region_t region;
  logic [17:0]      xfade;

  always_comb begin
    drive_gain = 20'd32768 + 20'd9 * 20'(drive_r);
    if (curve_r < wsd_pkg::SHAPE_B1) begin
      region = wsd_pkg::REGION_SINE_CUBIC;
      xfade  = 18'd3 * 18'(curve_r);
    end else if (curve_r < wsd_pkg::SHAPE_B2) begin
      region = wsd_pkg::REGION_CUBIC_ATAN;
      xfade  = 18'd3 * 18'(curve_r - wsd_pkg::SHAPE_B1);
    end else begin
      region = wsd_pkg::REGION_ATAN_HARD;
      xfade  = 18'd3 * 18'(curve_r - wsd_pkg::SHAPE_B2);
    end
  end

  // Three restoring division steps of the hard-knee quotient.
  function automatic div_t div_step3(input div_t d_in, input logic [15:0] dv);
    div_t d;
    logic [16:0] trial;
    d = d_in;
    for (int k = 0; k < 3; k++) begin
      trial = {d.rem, d.nb[14]};
      d.nb  = {d.nb[13:0], 1'b0};
      if (trial >= {1'b0, dv}) begin
        d.rem = 16'(trial - {1'b0, dv});
        d.q   = {d.q[13:0], 1'b1};
      end else begin
        d.rem = trial[15:0];
        d.q   = {d.q[13:0], 1'b0};
      end
    end
    return d;
  endfunction

  pipe_t       p_r   [NS];
  pipe_t       p_nxt [NS];
  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  // A stage moves when it is empty or when the stage after it moves.
  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_ch.ready;
    for (int k = NS - 2; k >= 0; k--) en[k] = !v_r[k] || en[k+1];
  end

  assign in_ch.ready = en[0];

  // Table lookups for the sine and arctangent curves, registered into stage 3.
  logic [TABLE_BITS:0] addr_lo, addr_hi;
  logic [15:0] sin_lo_r, sin_hi_r, atn_lo_r, atn_hi_r;

  assign addr_lo = {1'b0, p_r[2].idx};
  assign addr_hi = {1'b0, p_r[2].idx} + 1'b1;

  wsd_table_rom #(.TABLE_BITS(TABLE_BITS), .KIND(wsd_pkg::TAB_SINE)) u_sin_rom (
    .clk(clk), .en(en[3]), .addr_a(addr_lo), .addr_b(addr_hi),
    .data_a_r(sin_lo_r), .data_b_r(sin_hi_r)
  );

  wsd_table_rom #(.TABLE_BITS(TABLE_BITS), .KIND(wsd_pkg::TAB_ATAN)) u_atn_rom (
    .clk(clk), .en(en[3]), .addr_a(addr_lo), .addr_b(addr_hi),
    .data_a_r(atn_lo_r), .data_b_r(atn_hi_r)
  );

  localparam logic signed [37:0] X_LIM = 38'sd3 <<< 30;

  always_comb begin
    logic signed [37:0] xc;
    logic signed [16:0] xv;
    logic [15:0]        uv;
    logic [15:0]        dvv;
    div_t               dd;
    logic signed [17:0] dif;
    logic signed [34:0] prod;
    logic signed [51:0] cv;
    logic signed [17:0] aa, bb;
    logic signed [41:0] o30;
    logic signed [60:0] acc;

    xc = '0; xv = '0; uv = '0; dvv = '0; dd = '0; dif = '0; prod = '0;
    cv = '0; aa = '0; bb = '0; o30 = '0; acc = '0;

    // Stage 0: capture the beat and apply the symmetry offset.
    p_nxt[0]    = p_r[0];
    p_nxt[0].s  = in_ch.sample;
    p_nxt[0].pt = in_ch.pass_through;
    p_nxt[0].t  = (18'(in_ch.sample) <<< 1) + $signed({2'b00, bias_r}) - 18'sd16384;

    // Stage 1: drive gain.
    p_nxt[1]     = p_r[0];
    p_nxt[1].x31 = 38'(p_r[0].t * $signed({1'b0, drive_gain}));

    // Stage 2: clamp, rescale to Q.15, split for table lookup and set up the divider.
    p_nxt[2] = p_r[1];
    xc = p_r[1].x31;
    if (xc > X_LIM) xc = X_LIM;
    if (xc < -X_LIM) xc = -X_LIM;
    xv  = 17'((xc + 38'sd32768) >>> 16);
    uv  = (xv < 0) ? 16'(-xv) : 16'(xv);
    dvv = uv + wsd_pkg::HARD_KNEE;
    p_nxt[2].x    = xv;
    p_nxt[2].neg  = xv < 0;
    p_nxt[2].idx  = TABLE_BITS'(uv >> (16 - TABLE_BITS));
    p_nxt[2].frac = 16'(uv << TABLE_BITS);
    p_nxt[2].dv   = dvv;
    p_nxt[2].rem  = uv;
    p_nxt[2].nb   = dvv[15:1];
    p_nxt[2].q    = '0;

    // Stage 3: square for the cubic, first divider step (tables read here).
    p_nxt[3]     = p_r[2];
    p_nxt[3].xsq = 32'(p_r[2].x * p_r[2].x);
    dd = div_step3({p_r[2].rem, p_r[2].nb, p_r[2].q}, p_r[2].dv);
    p_nxt[3].rem = dd.rem; p_nxt[3].nb = dd.nb; p_nxt[3].q = dd.q;

    // Stage 4: interpolate both tables, cube, divider.
    p_nxt[4] = p_r[3];
    dif  = $signed({2'b00, sin_hi_r}) - $signed({2'b00, sin_lo_r});
    prod = 35'(dif * $signed({1'b0, p_r[3].frac}));
    p_nxt[4].sy = $signed({2'b00, sin_lo_r}) + 18'(prod >>> 16);
    dif  = $signed({2'b00, atn_hi_r}) - $signed({2'b00, atn_lo_r});
    prod = 35'(dif * $signed({1'b0, p_r[3].frac}));
    p_nxt[4].ay = $signed({2'b00, atn_lo_r}) + 18'(prod >>> 16);
    p_nxt[4].x3 = 50'($signed({1'b0, p_r[3].xsq}) * p_r[3].x);
    dd = div_step3({p_r[3].rem, p_r[3].nb, p_r[3].q}, p_r[3].dv);
    p_nxt[4].rem = dd.rem; p_nxt[4].nb = dd.nb; p_nxt[4].q = dd.q;

    // Stage 5: cubic curve and the sign of the table curves.
    p_nxt[5] = p_r[4];
    cv = ((52'(p_r[4].x) * 52'sd3) <<< 30) - 52'(p_r[4].x3) + (52'sd1 <<< 30);
    p_nxt[5].cub = 18'(cv >>> 31);
    p_nxt[5].sy  = p_r[4].neg ? -p_r[4].sy : p_r[4].sy;
    p_nxt[5].ay  = p_r[4].neg ? -p_r[4].ay : p_r[4].ay;
    dd = div_step3({p_r[4].rem, p_r[4].nb, p_r[4].q}, p_r[4].dv);
    p_nxt[5].rem = dd.rem; p_nxt[5].nb = dd.nb; p_nxt[5].q = dd.q;

    // Stage 6: divider.
    p_nxt[6] = p_r[5];
    dd = div_step3({p_r[5].rem, p_r[5].nb, p_r[5].q}, p_r[5].dv);
    p_nxt[6].rem = dd.rem; p_nxt[6].nb = dd.nb; p_nxt[6].q = dd.q;

    // Stage 7: last divider step gives the hard-knee curve.
    p_nxt[7] = p_r[6];
    dd = div_step3({p_r[6].rem, p_r[6].nb, p_r[6].q}, p_r[6].dv);
    p_nxt[7].q  = dd.q;
    p_nxt[7].hy = p_r[6].neg ? -$signed({3'b000, dd.q}) : $signed({3'b000, dd.q});

    // Stage 8: pick the curve pair and weight both sides of the crossfade.
    p_nxt[8] = p_r[7];
    case (region)
      wsd_pkg::REGION_SINE_CUBIC: begin aa = p_r[7].sy;  bb = p_r[7].cub; end
      wsd_pkg::REGION_CUBIC_ATAN: begin aa = p_r[7].cub; bb = p_r[7].ay;  end
      default:                    begin aa = p_r[7].ay;  bb = p_r[7].hy;  end
    endcase
    p_nxt[8].pa = 37'(aa * (19'sd32768 - $signed({1'b0, xfade})));
    p_nxt[8].pb = 37'(bb * $signed({1'b0, xfade}));

    // Stage 9: crossfade sum, rounded back to Q.15.
    p_nxt[9] = p_r[8];
    p_nxt[9].curve_y = 24'((38'(p_r[8].pa) + 38'(p_r[8].pb) + 38'sd16384) >>> 15);

    // Stage 10: dry and wet products.
    p_nxt[10] = p_r[9];
    p_nxt[10].ps = 33'(p_r[9].s * (17'sd32768 - $signed({1'b0, wet_r})));
    p_nxt[10].pd = 41'(p_r[9].curve_y * $signed({1'b0, wet_r}));

    // Stage 11: mix, split into halves for the gain multiply.
    p_nxt[11] = p_r[10];
    o30 = 42'(p_r[10].ps) + 42'(p_r[10].pd);
    p_nxt[11].oh = o30[41:19];
    p_nxt[11].ol = o30[18:0];

    // Stage 12: output gain as two partial products.
    p_nxt[12] = p_r[11];
    p_nxt[12].ph = 40'(p_r[11].oh * $signed({1'b0, gain_r}));
    p_nxt[12].pl = 35'(p_r[11].ol * gain_r);

    // Stage 13: recombine and round to Q.15.
    p_nxt[13] = p_r[12];
    acc = (61'(p_r[12].ph) <<< 19) + 61'($signed({1'b0, p_r[12].pl})) + (61'sd1 <<< 29);
    p_nxt[13].r = 31'(acc >>> 30);

    // Stage 14: saturate, or hand the dry sample straight through.
    p_nxt[14] = p_r[13];
    if (p_r[13].pt) begin
      p_nxt[14].out_sample = p_r[13].s;
      p_nxt[14].clipped    = 1'b0;
    end else if (p_r[13].r > 31'sd32767) begin
      p_nxt[14].out_sample = 16'sh7fff;
      p_nxt[14].clipped    = 1'b1;
    end else if (p_r[13].r < -31'sd32768) begin
      p_nxt[14].out_sample = 16'sh8000;
      p_nxt[14].clipped    = 1'b1;
    end else begin
      p_nxt[14].out_sample = 16'(p_r[13].r);
      p_nxt[14].clipped    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_ch.valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) p_r[k] <= p_nxt[k];
    end
  end

  assign out_ch.valid      = v_r[NS-1];
  assign out_ch.out_sample = p_r[NS-1].out_sample;
  assign out_ch.clipped    = p_r[NS-1].clipped;

endmodule

[hdl/wsd_table_rom.sv]
// Shape table ROM with two registered read ports (entry and its neighbor).
// Contents are built at elaboration from the series functions in wsd_pkg.
module wsd_table_rom #(
  parameter int                  TABLE_BITS = wsd_pkg::TABLE_BITS_DEF,
  parameter wsd_pkg::table_kind_t KIND      = wsd_pkg::TAB_SINE
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [TABLE_BITS:0]   addr_a,
  input  logic [TABLE_BITS:0]   addr_b,
  output logic [15:0]           data_a_r,
  output logic [15:0]           data_b_r
);

  localparam int TSIZE = (1 << TABLE_BITS) + 1;

  typedef logic [15:0] rom_t [TSIZE];

  function automatic rom_t build_rom();
    rom_t t;
    for (int i = 0; i < TSIZE; i++) begin
      if (KIND == wsd_pkg::TAB_SINE) t[i] = wsd_pkg::sin_entry(longint'(i), TABLE_BITS);
      else t[i] = wsd_pkg::atan_entry(longint'(i), TABLE_BITS);
    end
    return t;
  endfunction

  localparam rom_t ROM = build_rom();

  always_ff @(posedge clk) begin
    if (en) begin
      data_a_r <= ROM[addr_a];
      data_b_r <= ROM[addr_b];
    end
  end

endmodule
